@@ src/dsw_pkg.sv @@
// shared types and constants for the dual servo slew and wag block
package dsw_pkg;

  localparam int unsigned AngleW = 8;
  localparam int unsigned PauseW = 10;
  localparam int unsigned ActW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [AngleW-1:0] StepDegRst   = 8'd2;
  localparam logic [AngleW-1:0] StepIntRst   = 8'd15;
  localparam logic [PauseW-1:0] WagPauseRst  = 10'd100;
  localparam logic [AngleW-1:0] HeadMinRst   = 8'd0;
  localparam logic [AngleW-1:0] HeadMaxRst   = 8'd180;
  localparam logic [AngleW-1:0] TailMinRst   = 8'd0;
  localparam logic [AngleW-1:0] TailMaxRst   = 8'd180;
  localparam logic [AngleW-1:0] TailCenterRst = 8'd90;

  localparam logic [2:0] WagPhaseLow  = 3'd2;
  localparam logic [2:0] WagPhaseHi1  = 3'd1;
  localparam logic [2:0] WagPhaseHi2  = 3'd3;

  typedef enum logic [ActW-1:0] {
    ACT_TICK      = 3'd0,
    ACT_HEAD_EN   = 3'd1,
    ACT_TAIL_EN   = 3'd2,
    ACT_HEAD_GOAL = 3'd3,
    ACT_TAIL_GOAL = 3'd4,
    ACT_WAG       = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_DEG  = 3'd0,
    REG_STEP_INT  = 3'd1,
    REG_WAG_PAUSE = 3'd2,
    REG_HEAD_MIN  = 3'd3,
    REG_HEAD_MAX  = 3'd4,
    REG_TAIL_MIN  = 3'd5,
    REG_TAIL_MAX  = 3'd6,
    REG_TAIL_CTR  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [AngleW-1:0] step_degrees;
    logic [AngleW-1:0] step_interval;
    logic [PauseW-1:0] wag_pause;
    logic [AngleW-1:0] head_min;
    logic [AngleW-1:0] head_max;
    logic [AngleW-1:0] tail_min;
    logic [AngleW-1:0] tail_max;
    logic [AngleW-1:0] tail_center;
  } cfg_t;

  typedef struct packed {
    logic              accepted;
    logic [AngleW-1:0] head_angle;
    logic [AngleW-1:0] tail_angle;
    logic              head_on;
    logic              tail_on;
    logic              head_moving;
    logic              tail_moving;
  } res_t;

endpackage

@@ src/dual_servo_slew_and_wag.sv @@
// Dual servo slew limiter with tail wag. Each input transaction (a millisecond
// tick or a command) is taken into an input register, processed in one pass
// against the servo state and written to an output register, which offers the
// result. One transaction is taken every cycle; the input register only stalls
// while a finished result sits unread in the output register. Every transaction
// returns exactly one result. Configuration registers take effect for the next
// transaction processed and should be written only while no transaction is in
// flight.
module dual_servo_slew_and_wag
  import dsw_pkg::*;
#(
  parameter int unsigned HEAD_CENTER = 90
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ActW-1:0]     action_i,
  input  logic                enable_value_i,
  input  logic [AngleW-1:0]   angle_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                accepted_o,
  output logic [AngleW-1:0]   head_angle_o,
  output logic [AngleW-1:0]   tail_angle_o,
  output logic                head_on_o,
  output logic                tail_on_o,
  output logic                head_moving_o,
  output logic                tail_moving_o
);

  cfg_t              cfg;
  res_t              res, res_q;
  logic              in_vld_q, out_vld_q;
  logic [ActW-1:0]   act_q;
  logic              en_q;
  logic [AngleW-1:0] ang_q;
  logic              adv, fire;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  dsw_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  dsw_core #(
    .HeadCenter (HEAD_CENTER)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .fire_i (fire),
    .act_i  (act_q),
    .en_i   (en_q),
    .ang_i  (ang_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q <= action_i;
      en_q  <= enable_value_i;
      ang_q <= angle_value_i;
    end
    if (fire) res_q <= res;
  end

  assign out_valid_o   = out_vld_q;
  assign accepted_o    = res_q.accepted;
  assign head_angle_o  = res_q.head_angle;
  assign tail_angle_o  = res_q.tail_angle;
  assign head_on_o     = res_q.head_on;
  assign tail_on_o     = res_q.tail_on;
  assign head_moving_o = res_q.head_moving;
  assign tail_moving_o = res_q.tail_moving;

endmodule

@@ src/dsw_cfg.sv @@
// configuration register file
module dsw_cfg
  import dsw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_degrees  <= StepDegRst;
      cfg_q.step_interval <= StepIntRst;
      cfg_q.wag_pause     <= WagPauseRst;
      cfg_q.head_min      <= HeadMinRst;
      cfg_q.head_max      <= HeadMaxRst;
      cfg_q.tail_min      <= TailMinRst;
      cfg_q.tail_max      <= TailMaxRst;
      cfg_q.tail_center   <= TailCenterRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_DEG:  cfg_q.step_degrees  <= cfg_data_i[AngleW-1:0];
        REG_STEP_INT:  cfg_q.step_interval <= cfg_data_i[AngleW-1:0];
        REG_WAG_PAUSE: cfg_q.wag_pause     <= cfg_data_i[PauseW-1:0];
        REG_HEAD_MIN:  cfg_q.head_min      <= cfg_data_i[AngleW-1:0];
        REG_HEAD_MAX:  cfg_q.head_max      <= cfg_data_i[AngleW-1:0];
        REG_TAIL_MIN:  cfg_q.tail_min      <= cfg_data_i[AngleW-1:0];
        REG_TAIL_MAX:  cfg_q.tail_max      <= cfg_data_i[AngleW-1:0];
        REG_TAIL_CTR:  cfg_q.tail_center   <= cfg_data_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dsw_core.sv @@
// servo state registers and the single-pass update for one transaction
module dsw_core
  import dsw_pkg::*;
#(
  parameter int unsigned HeadCenter = 90
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              fire_i,
  input  logic [ActW-1:0]   act_i,
  input  logic              en_i,
  input  logic [AngleW-1:0] ang_i,
  output res_t              res_o
);

  localparam logic [AngleW-1:0] HeadRst = AngleW'(HeadCenter);
  localparam logic [AngleW-1:0] MoveMax = {AngleW{1'b1}};
  localparam logic [PauseW-1:0] PauseMax = {PauseW{1'b1}};

  logic              head_en_q, head_en_d, tail_en_q, tail_en_d;
  logic [AngleW-1:0] head_pos_q, head_pos_d, tail_pos_q, tail_pos_d;
  logic [AngleW-1:0] head_goal_q, head_goal_d, tail_goal_q, tail_goal_d;
  logic [AngleW-1:0] move_q, move_d;
  logic              wag_on_q, wag_on_d, armed_q, armed_d;
  logic [2:0]        phase_q, phase_d;
  logic [PauseW-1:0] pause_q, pause_d;
  logic              ok;

  logic [AngleW-1:0] move_inc, head_step, tail_step;
  logic              step_go, wag_hit;
  logic [PauseW-1:0] pause_inc;
  logic [2:0]        phase_nx;

  function automatic logic [AngleW-1:0] slew(input logic [AngleW-1:0] pos,
                                            input logic [AngleW-1:0] goal,
                                            input logic [AngleW-1:0] lim);
    logic              up;
    logic [AngleW-1:0] diff;
    up   = goal > pos;
    diff = up ? goal - pos : pos - goal;
    if (diff > lim) diff = lim;
    return up ? pos + diff : pos - diff;
  endfunction

  // tick path: movement interval, slew step, pause count
  assign move_inc  = (move_q != MoveMax) ? move_q + 1'b1 : move_q;
  assign step_go   = move_inc >= cfg_i.step_interval;
  assign head_step = (step_go && head_en_q) ?
                     slew(head_pos_q, head_goal_q, cfg_i.step_degrees) : head_pos_q;
  assign tail_step = (step_go && tail_en_q) ?
                     slew(tail_pos_q, tail_goal_q, cfg_i.step_degrees) : tail_pos_q;
  assign pause_inc = (armed_q && pause_q != PauseMax) ? pause_q + 1'b1 : pause_q;
  assign wag_hit   = wag_on_q && tail_en_q && (tail_step == tail_goal_q);
  assign phase_nx  = phase_q + 3'd1;

  always_comb begin
    head_en_d   = head_en_q;
    tail_en_d   = tail_en_q;
    head_pos_d  = head_pos_q;
    tail_pos_d  = tail_pos_q;
    head_goal_d = head_goal_q;
    tail_goal_d = tail_goal_q;
    move_d      = move_q;
    wag_on_d    = wag_on_q;
    armed_d     = armed_q;
    phase_d     = phase_q;
    pause_d     = pause_q;
    ok          = 1'b0;
    unique case (act_i)
      ACT_TICK: begin
        ok         = 1'b1;
        move_d     = step_go ? '0 : move_inc;
        head_pos_d = head_step;
        tail_pos_d = tail_step;
        pause_d    = pause_inc;
        if (wag_hit) begin
          if (!armed_q) begin
            armed_d = 1'b1;
            pause_d = '0;
          end else if (pause_inc >= cfg_i.wag_pause) begin
            armed_d = 1'b0;
            pause_d = '0;
            phase_d = phase_nx;
            if (phase_nx == WagPhaseHi1 || phase_nx == WagPhaseHi2) begin
              tail_goal_d = cfg_i.tail_max;
            end else if (phase_nx == WagPhaseLow) begin
              tail_goal_d = cfg_i.tail_min;
            end else begin
              // last leg: back to rest and the wag is over
              tail_goal_d = cfg_i.tail_center;
              wag_on_d    = 1'b0;
              phase_d     = '0;
            end
          end
        end
      end
      ACT_HEAD_EN: begin
        ok        = 1'b1;
        head_en_d = en_i;
      end
      ACT_TAIL_EN: begin
        ok = 1'b1;
        if (en_i != tail_en_q) begin
          tail_en_d = en_i;
          wag_on_d  = 1'b0;
          phase_d   = '0;
        end
      end
      ACT_HEAD_GOAL: begin
        if (head_en_q && ang_i >= cfg_i.head_min && ang_i <= cfg_i.head_max) begin
          ok          = 1'b1;
          head_goal_d = ang_i;
        end
      end
      ACT_TAIL_GOAL: begin
        if (tail_en_q && ang_i >= cfg_i.tail_min && ang_i <= cfg_i.tail_max) begin
          ok          = 1'b1;
          tail_goal_d = ang_i;
          wag_on_d    = 1'b0;
          phase_d     = '0;
        end
      end
      ACT_WAG: begin
        if (tail_en_q) begin
          ok          = 1'b1;
          wag_on_d    = 1'b1;
          phase_d     = '0;
          armed_d     = 1'b0;
          pause_d     = '0;
          tail_goal_d = cfg_i.tail_min;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_en_q   <= 1'b0;
      tail_en_q   <= 1'b0;
      head_pos_q  <= HeadRst;
      tail_pos_q  <= TailCenterRst;
      head_goal_q <= HeadRst;
      tail_goal_q <= TailCenterRst;
      move_q      <= '0;
      wag_on_q    <= 1'b0;
      armed_q     <= 1'b0;
      phase_q     <= '0;
      pause_q     <= '0;
    end else if (fire_i) begin
      head_en_q   <= head_en_d;
      tail_en_q   <= tail_en_d;
      head_pos_q  <= head_pos_d;
      tail_pos_q  <= tail_pos_d;
      head_goal_q <= head_goal_d;
      tail_goal_q <= tail_goal_d;
      move_q      <= move_d;
      wag_on_q    <= wag_on_d;
      armed_q     <= armed_d;
      phase_q     <= phase_d;
      pause_q     <= pause_d;
    end
  end

  always_comb begin
    res_o.accepted    = ok;
    res_o.head_angle  = head_pos_d;
    res_o.tail_angle  = tail_pos_d;
    res_o.head_on     = head_en_d;
    res_o.tail_on     = tail_en_d;
    res_o.head_moving = head_en_d && (head_pos_d != head_goal_d);
    res_o.tail_moving = tail_en_d && ((tail_pos_d != tail_goal_d) || wag_on_d);
  end

endmodule

@@ src/dsw_checker.sv @@
// port-level checks for the servo block, bound to the top level
module dsw_checker
  import dsw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [AngleW-1:0] head_angle_o,
  input logic [AngleW-1:0] tail_angle_o,
  input logic              head_on_o,
  input logic              tail_on_o,
  input logic              head_moving_o,
  input logic              tail_moving_o
);

  // a servo that is off never reports motion
  a_head_moving_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && head_moving_o |-> head_on_o)
    else $error("head moving while disabled");

  a_tail_moving_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tail_moving_o |-> tail_on_o)
    else $error("tail moving while disabled");

  // consecutive results with the head disabled keep the head angle
  a_head_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !head_on_o) ##1 (out_valid_o && !head_on_o)
    |-> head_angle_o == $past(head_angle_o))
    else $error("head angle changed while disabled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tail_angle_o))
    else $error("stalled result changed");

endmodule

bind dual_servo_slew_and_wag dsw_checker u_dsw_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the dual servo slew and wag block with its own status predictor
module testbench;
  import dsw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [AngleW-1:0] HEAD_REST = 8'd90;
  localparam logic [ActW-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ActW-1:0] cmd_action = '0;
  logic enable_value = 1'b0;
  logic [AngleW-1:0] angle_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted;
  logic [AngleW-1:0] head_angle;
  logic [AngleW-1:0] tail_angle;
  logic head_on;
  logic tail_on;
  logic head_moving;
  logic tail_moving;

  // servo status mirror
  cfg_t cfg_m = '{StepDegRst, StepIntRst, WagPauseRst, HeadMinRst, HeadMaxRst,
                  TailMinRst, TailMaxRst, TailCenterRst};
  logic head_on_m = 1'b0;
  logic tail_on_m = 1'b0;
  logic [AngleW-1:0] head_ang_m = HEAD_REST;
  logic [AngleW-1:0] head_goal_m = HEAD_REST;
  logic [AngleW-1:0] tail_ang_m = TailCenterRst;
  logic [AngleW-1:0] tail_goal_m = TailCenterRst;
  logic [7:0] move_ticks_m = '0;
  logic wagging_m = 1'b0;
  logic [2:0] wag_phase_m = '0;
  logic hold_armed_m = 1'b0;
  logic [PauseW-1:0] hold_ticks_m = '0;

  res_t status_q[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned wags_done = 0;
  int unsigned refused_cnt = 0;
  int unsigned settings_written = 0;
  int unsigned cycles = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  dual_servo_slew_and_wag u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (cmd_action),
    .enable_value_i (enable_value),
    .angle_value_i  (angle_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .head_angle_o   (head_angle),
    .tail_angle_o   (tail_angle),
    .head_on_o      (head_on),
    .tail_on_o      (tail_on),
    .head_moving_o  (head_moving),
    .tail_moving_o  (tail_moving)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [AngleW-1:0] slew_toward(logic [AngleW-1:0] pos,
                                                     logic [AngleW-1:0] goal);
    logic [AngleW-1:0] diff;
    diff = (goal > pos) ? goal - pos : pos - goal;
    if (diff > cfg_m.step_degrees) diff = cfg_m.step_degrees;
    return (goal > pos) ? pos + diff : pos - diff;
  endfunction

  function automatic logic [AngleW-1:0] rand_ang(int unsigned lo, int unsigned hi);
    return AngleW'($urandom_range(lo, hi));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic predict_status(input logic [ActW-1:0] act, input logic en,
                                input logic [AngleW-1:0] ang);
    res_t r;
    logic ok;
    ok = 1'b0;
    case (act)
      ACT_TICK: begin
        ok = 1'b1;
        if (move_ticks_m != 8'd255) move_ticks_m++;
        if (move_ticks_m >= cfg_m.step_interval) begin
          move_ticks_m = '0;
          if (head_on_m && head_ang_m != head_goal_m)
            head_ang_m = slew_toward(head_ang_m, head_goal_m);
          if (tail_on_m && tail_ang_m != tail_goal_m)
            tail_ang_m = slew_toward(tail_ang_m, tail_goal_m);
        end
        if (hold_armed_m && hold_ticks_m != 10'd1023) hold_ticks_m++;
        // wag advances only once the tail sits on its goal
        if (wagging_m && tail_on_m && tail_ang_m == tail_goal_m) begin
          if (!hold_armed_m) begin
            hold_armed_m = 1'b1;
            hold_ticks_m = '0;
          end else if (hold_ticks_m >= cfg_m.wag_pause) begin
            hold_armed_m = 1'b0;
            hold_ticks_m = '0;
            wag_phase_m = wag_phase_m + 3'd1;
            if (wag_phase_m == WagPhaseHi1 || wag_phase_m == WagPhaseHi2) begin
              tail_goal_m = cfg_m.tail_max;
            end else if (wag_phase_m == WagPhaseLow) begin
              tail_goal_m = cfg_m.tail_min;
            end else begin
              tail_goal_m = cfg_m.tail_center;
              wagging_m = 1'b0;
              wag_phase_m = '0;
              wags_done++;
            end
          end
        end
      end
      ACT_HEAD_EN: begin
        head_on_m = en;
        ok = 1'b1;
      end
      ACT_TAIL_EN: begin
        if (en != tail_on_m) begin
          wagging_m = 1'b0;
          wag_phase_m = '0;
          tail_on_m = en;
        end
        ok = 1'b1;
      end
      ACT_HEAD_GOAL: begin
        if (head_on_m && ang >= cfg_m.head_min && ang <= cfg_m.head_max) begin
          head_goal_m = ang;
          ok = 1'b1;
        end
      end
      ACT_TAIL_GOAL: begin
        if (tail_on_m && ang >= cfg_m.tail_min && ang <= cfg_m.tail_max) begin
          wagging_m = 1'b0;
          wag_phase_m = '0;
          tail_goal_m = ang;
          ok = 1'b1;
        end
      end
      ACT_WAG: begin
        if (tail_on_m) begin
          wagging_m = 1'b1;
          wag_phase_m = '0;
          hold_armed_m = 1'b0;
          hold_ticks_m = '0;
          tail_goal_m = cfg_m.tail_min;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (!ok) refused_cnt++;
    r.accepted    = ok;
    r.head_angle  = head_ang_m;
    r.tail_angle  = tail_ang_m;
    r.head_on     = head_on_m;
    r.tail_on     = tail_on_m;
    r.head_moving = head_on_m && (head_ang_m != head_goal_m);
    r.tail_moving = tail_on_m && ((tail_ang_m != tail_goal_m) || wagging_m);
    status_q.push_back(r);
  endtask

  // called just after a rising edge; leaves valid high for a back-to-back transaction
  task automatic send_item(input logic [ActW-1:0] act, input logic en,
                           input logic [AngleW-1:0] ang);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_action <= act;
    enable_value <= en;
    angle_value <= ang;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_status(act, en, ang);
    items_sent++;
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    cfg_reg_e reg_sel;
    logic [1:0] pad;
    for (int i = 0; i < 8; i++) begin
      reg_sel = cfg_reg_e'(i);
      pad = 2'($urandom_range(0, 3));
      cfg_we <= 1'b1;
      cfg_idx <= reg_sel;
      // unused upper data bits of the 8 bit registers are randomized
      case (reg_sel)
        REG_STEP_DEG:  cfg_data <= {pad, c.step_degrees};
        REG_STEP_INT:  cfg_data <= {pad, c.step_interval};
        REG_WAG_PAUSE: cfg_data <= c.wag_pause;
        REG_HEAD_MIN:  cfg_data <= {pad, c.head_min};
        REG_HEAD_MAX:  cfg_data <= {pad, c.head_max};
        REG_TAIL_MIN:  cfg_data <= {pad, c.tail_min};
        REG_TAIL_MAX:  cfg_data <= {pad, c.tail_max};
        default:       cfg_data <= {pad, c.tail_center};
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_m = c;
    settings_written++;
  endtask

  task automatic pick_settings(output cfg_t c);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // quick wags: coarse steps, short interval and pause
      c.step_degrees  = rand_ang(45, 180);
      c.step_interval = rand_ang(0, 2);
      c.wag_pause     = PauseW'($urandom_range(0, 4));
      c.head_min      = rand_ang(0, 60);
      c.head_max      = rand_ang(120, 180);
      c.tail_min      = rand_ang(0, 60);
      c.tail_max      = rand_ang(120, 180);
      c.tail_center   = rand_ang(0, 180);
    end else if (kind < 8) begin
      c.step_degrees  = rand_ang(0, 255);
      c.step_interval = rand_ang(0, 255);
      c.wag_pause     = PauseW'($urandom_range(0, 1023));
      c.head_min      = rand_ang(0, 255);
      c.head_max      = rand_ang(0, 255);
      c.tail_min      = rand_ang(0, 255);
      c.tail_max      = rand_ang(0, 255);
      c.tail_center   = rand_ang(0, 255);
    end else begin
      case ($urandom_range(0, 3))
        0: c = '{8'd180, 8'd1, 10'd1, 8'd0, 8'd180, 8'd0, 8'd180, 8'd0};
        1: c = '{8'd1, 8'd255, 10'd1023, 8'd180, 8'd180, 8'd180, 8'd180, 8'd180};
        2: c = '{8'd0, 8'd0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        default: c = '{8'd255, 8'd255, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      endcase
    end
  endtask

  task automatic send_noise;
    logic [ActW-1:0] act;
    logic [AngleW-1:0] lo;
    logic [AngleW-1:0] hi;
    logic [AngleW-1:0] ang;
    if ($urandom_range(0, 9) < 3) act = ACT_TICK;
    else act = ActW'($urandom_range(1, 7));
    lo = (act == ACT_HEAD_GOAL) ? cfg_m.head_min : cfg_m.tail_min;
    hi = (act == ACT_HEAD_GOAL) ? cfg_m.head_max : cfg_m.tail_max;
    if (lo <= hi && $urandom_range(0, 1) == 1) ang = rand_ang(lo, hi);
    else ang = rand_ang(0, 255);
    send_item(act, rand_bit(), ang);
  endtask

  // enable the tail, maybe aim the head, start a wag, feed ticks until done or out of budget
  task automatic run_wag_cycle;
    int budget;
    int n;
    logic [AngleW-1:0] ang;
    budget = $urandom_range(20, 80);
    send_item(ACT_TAIL_EN, 1'b1, rand_ang(0, 255));
    if ($urandom_range(0, 1) == 1) begin
      if (cfg_m.head_min <= cfg_m.head_max) ang = rand_ang(cfg_m.head_min, cfg_m.head_max);
      else ang = rand_ang(0, 255);
      send_item(ACT_HEAD_EN, 1'b1, rand_ang(0, 255));
      send_item(ACT_HEAD_GOAL, rand_bit(), ang);
    end
    send_item(ACT_WAG, rand_bit(), rand_ang(0, 255));
    n = 0;
    while (wagging_m && n < budget) begin
      if ($urandom_range(0, 24) == 0) send_noise();
      else send_item(ACT_TICK, rand_bit(), rand_ang(0, 255));
      n++;
    end
  endtask

  task automatic test_disabled_commands;
    send_item(ACT_TICK, 1'b0, 8'd0);
    send_item(ACT_HEAD_GOAL, 1'b1, 8'd0);
    send_item(ACT_TAIL_GOAL, 1'b1, 8'd180);
    send_item(ACT_WAG, 1'b1, 8'd255);
    send_item(ACT_SPARE_A, 1'b1, 8'd255);
    send_item(ACT_SPARE_B, 1'b0, 8'd0);
    send_item(ACT_HEAD_EN, 1'b0, 8'd0);
    send_item(ACT_TAIL_EN, 1'b0, 8'd0);
  endtask

  task automatic test_enabled_commands;
    send_item(ACT_HEAD_EN, 1'b1, 8'd0);
    send_item(ACT_TAIL_EN, 1'b1, 8'd0);
    send_item(ACT_HEAD_GOAL, 1'b0, 8'd255);
    send_item(ACT_HEAD_GOAL, 1'b0, 8'd181);
    send_item(ACT_HEAD_GOAL, 1'b0, 8'd0);
    send_item(ACT_HEAD_GOAL, 1'b0, 8'd180);
    send_item(ACT_TAIL_GOAL, 1'b0, 8'd181);
    send_item(ACT_TAIL_GOAL, 1'b0, 8'd0);
    send_item(ACT_TICK, 1'b1, 8'd255);
    send_item(ACT_WAG, 1'b0, 8'd0);
    // head enable changes leave the wag running, a tail enable change stops it
    send_item(ACT_HEAD_EN, 1'b0, 8'd0);
    send_item(ACT_HEAD_EN, 1'b1, 8'd0);
    send_item(ACT_TAIL_EN, 1'b1, 8'd0);
    send_item(ACT_TAIL_EN, 1'b0, 8'd0);
    send_item(ACT_TAIL_EN, 1'b1, 8'd0);
  endtask

  task automatic test_special_settings;
    wait_idle();
    // zero step size, zero interval and zero pause
    program_regs('{8'd0, 8'd0, 10'd0, HeadMinRst, HeadMaxRst, TailMinRst, TailMaxRst,
                   TailCenterRst});
    send_item(ACT_HEAD_GOAL, 1'b1, 8'd10);
    send_item(ACT_TICK, 1'b0, 8'd0);
    wait_idle();
    program_regs('{8'd180, 8'd0, 10'd0, HeadMinRst, HeadMaxRst, TailMinRst, TailMaxRst,
                   TailCenterRst});
    send_item(ACT_WAG, 1'b1, 8'd0);
    repeat (9) send_item(ACT_TICK, 1'b0, 8'd0);
    wait_idle();
    // min above max refuses every goal
    program_regs('{8'd2, 8'd15, 10'd100, 8'd200, 8'd10, 8'd150, 8'd20, 8'd90});
    send_item(ACT_HEAD_GOAL, 1'b0, 8'd100);
    send_item(ACT_TAIL_GOAL, 1'b1, 8'd150);
  endtask

  task automatic test_random_phases;
    int unsigned start;
    int unsigned phase_start;
    cfg_t c;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      pick_settings(c);
      program_regs(c);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) run_wag_cycle();
        else repeat ($urandom_range(1, 10)) send_noise();
      end
    end
  endtask

  // result side: random stall length drawn per transaction
  initial begin
    int n;
    forever begin
      n = out_stalls_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d (transaction %0d)", $time, name, want_v,
                 got_v, results_seen);
    end
  endtask

  always @(posedge clk) begin : status_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected transaction, head %0d tail %0d", $time, head_angle,
                   tail_angle);
      end else begin
        want = status_q.pop_front();
        check_field("accepted", want.accepted, accepted);
        check_field("head_angle", want.head_angle, head_angle);
        check_field("tail_angle", want.tail_angle, tail_angle);
        check_field("head_on", want.head_on, head_on);
        check_field("tail_on", want.tail_on, tail_on);
        check_field("head_moving", want.head_moving, head_moving);
        check_field("tail_moving", want.tail_moving, tail_moving);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_commands();
    test_enabled_commands();
    test_special_settings();
    test_random_phases();
    wait_idle();
    mismatches += status_q.size();
    $display("%0d transactions checked over %0d register settings, %0d commands refused",
             results_seen, settings_written, refused_cnt);
    $display("%0d tail wags ran back to center", wags_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
